[rtl/integer_to_ascii_formatter_assert.svh]
// Assertion macros for the integer to ASCII formatter.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ITOA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/itoa_pkg.sv]
// Shared types, codes and helpers for the integer to ASCII formatter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  // Conversion codes
  localparam logic [2:0] CONV_BIN  = 3'd0;
  localparam logic [2:0] CONV_SDEC = 3'd1;
  localparam logic [2:0] CONV_OCT  = 3'd2;
  localparam logic [2:0] CONV_UDEC = 3'd3;
  localparam logic [2:0] CONV_HEXL = 3'd4;
  localparam logic [2:0] CONV_HEXU = 3'd5;
  localparam logic [2:0] CONV_CHAR = 3'd6;
  localparam logic [2:0] CONV_NONE = 3'd7;

  // ASCII characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Field width counters (width up to 63)
  localparam int FIELD_W = 6;
  // Digit counters: covers the digit register for values up to 64 bits (84 slots)
  localparam int CNT_W = 7;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  conversion;
    logic [5:0]  width;
    logic        left_adjust;
    logic        zero_pad;
  } item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } result_t;

  // Digit generator to emitter: digits ready, sign, significant digit count
  typedef struct packed {
    logic             done;
    logic             neg;
    logic [CNT_W-1:0] nd;
  } digit_info_t;

  // One digit (0..15) to its ASCII character
  function automatic logic [7:0] digit_ascii(input logic [3:0] digit, input logic upper);
    logic [7:0] d8;
    d8 = {4'b0000, digit};
    if (digit <= 4'd9) begin
      digit_ascii = CH_ZERO + d8;
    end else if (upper) begin
      digit_ascii = CH_UPA + d8 - 8'd10;
    end else begin
      digit_ascii = CH_LOWA + d8 - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/itoa_digits.sv]
// Digit generator: bit-serial binary to BCD (double dabble) for decimal, then a
// digit shift register that strips leading zeros and pops digits MSB first.
// Depends on itoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itoa_digits import itoa_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire logic [31:0] value,
  input  wire logic [2:0]  conversion,
  input  wire logic        pop,
  output digit_info_t      info,
  output logic [7:0]       digit_char
);

  // Decimal digits for VALUE_BITS bits: floor(bits * log10(2)) + 1
  localparam int NBCD  = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int BCDW  = NBCD * 4;
  localparam int RAWW  = (VALUE_BITS > BCDW) ? VALUE_BITS : BCDW;
  // Multiple of 12 so 1-, 3- and 4-bit digits all tile the register
  localparam int DRW   = ((RAWW + 11) / 12) * 12;
  localparam int SLOTS1 = DRW;
  localparam int SLOTS3 = DRW / 3;
  localparam int SLOTS4 = DRW / 4;
  localparam int BCW   = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {D_IDLE, D_DABBLE, D_STRIP, D_HOLD} dstate_t;
  typedef enum logic [1:0] {DSZ_1, DSZ_3, DSZ_4} dsz_t;

  dstate_t               state;
  dsz_t                  dsz;
  logic [DRW-1:0]        dr;
  logic [VALUE_BITS-1:0] src;
  logic [BCW-1:0]        bit_cnt;
  logic [CNT_W-1:0]      rem;
  logic                  neg;
  logic                  upper;
  logic                  is_char;
  logic [7:0]            chr;
  logic                  done;

  logic [VALUE_BITS+31:0] val_ext;
  logic [VALUE_BITS-1:0]  val_vb;
  logic                   is_neg;
  logic [VALUE_BITS-1:0]  mag;
  logic [DRW+VALUE_BITS-1:0] mag_wide;
  logic [DRW-1:0]         mag_ext;
  logic [BCDW-1:0]        bcd_adj;
  logic [BCDW-1:0]        bcd_next;
  logic [DRW+BCDW-1:0]    bcd_wide;
  logic [3:0]             digit;
  logic [DRW-1:0]         dr_shift;

  // Operand: low VALUE_BITS of the argument, magnitude for negative signed decimal
  always_comb begin
    val_ext  = {{VALUE_BITS{1'b0}}, value};
    val_vb   = val_ext[VALUE_BITS-1:0];
    is_neg   = (conversion == CONV_SDEC) && val_vb[VALUE_BITS-1];
    mag      = is_neg ? (~val_vb + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : val_vb;
    mag_wide = {{DRW{1'b0}}, mag};
    mag_ext  = mag_wide[DRW-1:0];
  end

  // Double dabble step: add 3 to every BCD digit >= 5, then shift in the next bit
  always_comb begin
    for (int k = 0; k < NBCD; k++) begin
      bcd_adj[4*k +: 4] = (dr[4*k +: 4] >= 4'd5) ? dr[4*k +: 4] + 4'd3 : dr[4*k +: 4];
    end
    bcd_next = {bcd_adj[BCDW-2:0], src[VALUE_BITS-1]};
    bcd_wide = {{DRW{1'b0}}, bcd_next};
  end

  // Top digit and one-digit shift for the current radix
  always_comb begin
    unique case (dsz)
      DSZ_1: begin
        digit    = {3'b000, dr[DRW-1]};
        dr_shift = {dr[DRW-2:0], 1'b0};
      end
      DSZ_3: begin
        digit    = {1'b0, dr[DRW-1 -: 3]};
        dr_shift = {dr[DRW-4:0], 3'b000};
      end
      default: begin
        digit    = dr[DRW-1 -: 4];
        dr_shift = {dr[DRW-5:0], 4'b0000};
      end
    endcase
  end

  // Sequencer and digit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        neg     <= is_neg;
        upper   <= (conversion == CONV_HEXU);
        is_char <= (conversion == CONV_CHAR);
        chr     <= value[7:0];
        unique case (conversion)
          CONV_CHAR: begin
            dsz   <= DSZ_4;
            rem   <= CNT_W'(1);
            state <= D_HOLD;
            done  <= 1'b1;
          end
          CONV_SDEC, CONV_UDEC: begin
            src     <= mag;
            dr      <= '0;
            bit_cnt <= BCW'(VALUE_BITS);
            dsz     <= DSZ_4;
            state   <= D_DABBLE;
          end
          CONV_BIN: begin
            dr    <= mag_ext;
            dsz   <= DSZ_1;
            rem   <= CNT_W'(SLOTS1);
            state <= D_STRIP;
          end
          CONV_OCT: begin
            dr    <= mag_ext;
            dsz   <= DSZ_3;
            rem   <= CNT_W'(SLOTS3);
            state <= D_STRIP;
          end
          CONV_HEXL, CONV_HEXU: begin
            dr    <= mag_ext;
            dsz   <= DSZ_4;
            rem   <= CNT_W'(SLOTS4);
            state <= D_STRIP;
          end
          default: begin
            state <= D_IDLE;
          end
        endcase
      end else begin
        unique case (state)
          D_DABBLE: begin
            dr      <= bcd_wide[DRW-1:0];
            src     <= {src[VALUE_BITS-2:0], 1'b0};
            bit_cnt <= bit_cnt - BCW'(1);
            if (bit_cnt == BCW'(1)) begin
              rem   <= CNT_W'(SLOTS4);
              state <= D_STRIP;
            end
          end
          // Drop leading zero digits, keep at least one
          D_STRIP: begin
            if (digit == 4'd0 && rem > CNT_W'(1)) begin
              dr  <= dr_shift;
              rem <= rem - CNT_W'(1);
            end else begin
              state <= D_HOLD;
              done  <= 1'b1;
            end
          end
          D_HOLD: begin
            if (pop) begin
              dr <= dr_shift;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign info       = '{done: done, neg: neg, nd: rem};
  assign digit_char = is_char ? chr : digit_ascii(digit, upper);

endmodule

`default_nettype wire

[rtl/itoa_emit.sv]
// Field emitter: sizes the padding and sends sign, padding and digits one
// character per cycle, MSB digit first. Depends on itoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itoa_emit import itoa_pkg::*; #(
  parameter int MAX_WIDTH = 63
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire digit_info_t        info,
  input  wire logic [FIELD_W-1:0] width_sat,
  input  wire logic               left_adjust,
  input  wire logic               zero_pad,
  input  wire logic [7:0]         digit_char,
  output logic                    pop,
  output logic                    strobe,
  output result_t                 result
);

  typedef enum logic {E_IDLE, E_RUN} estate_t;
  typedef enum logic [1:0] {SEL_SIGN, SEL_PAD, SEL_DIG} sel_t;

  estate_t            state;
  logic               sign_pend;
  logic [FIELD_W-1:0] pad;
  logic [CNT_W-1:0]   dig_rem;
  logic [FIELD_W-1:0] tot_rem;
  logic               left_m;
  logic               zpad_m;

  logic [CNT_W-1:0]   body;
  logic [CNT_W-1:0]   w_ext;
  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   pad_diff;
  logic [FIELD_W-1:0] pad_n;
  logic [FIELD_W-1:0] tot_n;
  sel_t               sel;
  logic [7:0]         ch;

  // Field size: body = digits + sign, padded up to width, cut at MAX_WIDTH
  always_comb begin
    body     = info.nd + CNT_W'(info.neg);
    w_ext    = CNT_W'(width_sat);
    total    = (body > w_ext) ? body : w_ext;
    pad_diff = w_ext - body;
    pad_n    = (body >= w_ext) ? '0 : pad_diff[FIELD_W-1:0];
    tot_n    = (total > CNT_W'(MAX_WIDTH)) ? FIELD_W'(MAX_WIDTH) : total[FIELD_W-1:0];
  end

  // Which piece comes next, by alignment mode
  always_comb begin
    if (left_m) begin
      priority if (sign_pend) sel = SEL_SIGN;
      else if (dig_rem != '0) sel = SEL_DIG;
      else                    sel = SEL_PAD;
    end else if (zpad_m) begin
      priority if (sign_pend) sel = SEL_SIGN;
      else if (pad != '0)     sel = SEL_PAD;
      else                    sel = SEL_DIG;
    end else begin
      priority if (pad != '0) sel = SEL_PAD;
      else if (sign_pend)     sel = SEL_SIGN;
      else                    sel = SEL_DIG;
    end
    unique case (sel)
      SEL_SIGN: ch = CH_MINUS;
      SEL_PAD:  ch = zpad_m ? CH_ZERO : CH_SPACE;
      default:  ch = digit_char;
    endcase
    pop = (state == E_RUN) && (sel == SEL_DIG);
  end

  // Sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (info.done) begin
            sign_pend <= info.neg;
            pad       <= pad_n;
            dig_rem   <= info.nd;
            tot_rem   <= tot_n;
            left_m    <= left_adjust;
            zpad_m    <= zero_pad && !left_adjust;
            state     <= E_RUN;
          end
        end
        default: begin
          strobe           <= 1'b1;
          result.character <= ch;
          result.last      <= (tot_rem == FIELD_W'(1));
          unique case (sel)
            SEL_SIGN: sign_pend <= 1'b0;
            SEL_PAD:  pad       <= pad - FIELD_W'(1);
            default:  dig_rem   <= dig_rem - CNT_W'(1);
          endcase
          tot_rem <= tot_rem - FIELD_W'(1);
          if (tot_rem == FIELD_W'(1)) begin
            state <= E_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/integer_to_ascii_formatter.sv]
// Top level of the integer to ASCII formatter (printf-style integer field).
// Depends on itoa_pkg, itoa_digits, itoa_emit and the assertion macro header.
//
//  channel   direction  transfer when         payload
//  item      in         start && !busy        item_t   (value, conversion, width, flags)
//  result    out        strobe                result_t (character, last)
//
// Per item: a load, then for decimal the serial binary-to-BCD shift over VALUE_BITS bits,
// then a leading zero strip in the digit shift register (DRW, the register holding the
// digits), a sizing step, one character per cycle, and the registered last character
// before busy drops. Code 7 produces nothing and leaves busy low.
// Synchronous active-high reset clears the sequencers and busy; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_formatter_assert.svh"

module integer_to_ascii_formatter import itoa_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 63
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire item_t item,
  output logic       busy,
  output logic       strobe,
  output result_t    result
);

  logic               accept;
  logic               load;
  logic [FIELD_W-1:0] width_q;
  logic               left_q;
  logic               zpad_q;
  digit_info_t        info;
  logic [7:0]         digit_char;
  logic               pop;

  assign accept = start && !busy;
  assign load   = accept && (item.conversion != CONV_NONE);

  // Busy from accepted conversion until its last character
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (strobe && result.last) begin
      busy <= 1'b0;
    end
  end

  // Field options, width saturated at MAX_WIDTH
  always_ff @(posedge clk) begin
    if (load) begin
      width_q <= (item.width > FIELD_W'(MAX_WIDTH)) ? FIELD_W'(MAX_WIDTH) : item.width;
      left_q  <= item.left_adjust;
      zpad_q  <= item.zero_pad && (item.conversion != CONV_CHAR);
    end
  end

  itoa_digits #(
    .VALUE_BITS(VALUE_BITS)
  ) u_digits (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .value      (item.value),
    .conversion (item.conversion),
    .pop        (pop),
    .info       (info),
    .digit_char (digit_char)
  );

  itoa_emit #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .info        (info),
    .width_sat   (width_q),
    .left_adjust (left_q),
    .zero_pad    (zpad_q),
    .digit_char  (digit_char),
    .pop         (pop),
    .strobe      (strobe),
    .result      (result)
  );

  // Checks
  `ITOA_ASSERT_NOW(a_strobe_busy, strobe, busy, "result transfer while not busy")
  `ITOA_ASSERT_NEXT(a_last_ends, strobe && result.last, !strobe, "character after last")
  `ITOA_ASSERT_NEXT(a_load_busy, load, busy, "accepted conversion did not set busy")
  `ITOA_ASSERT_NEXT(a_none_idle, accept && item.conversion == CONV_NONE, !busy,
                    "unused code left block busy")

endmodule

`default_nettype wire
